### design/ldq_pkg.sv
// shared item types and status codes for the look-direction quaternion unit
package ldq_pkg;

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
  } ldq_in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [1:0]         status;
  } ldq_out_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DIR  = 2'd1;
  localparam logic [1:0] STATUS_BAD_TRACE = 2'd2;

  // unit length of the front vector, Q.14
  localparam logic [15:0] FRONT_ONE = 16'd16384;

endpackage

### design/ldq_sqrt.sv
// pipelined integer square root, one root bit per stage
module ldq_sqrt import ldq_pkg::*; #(
  parameter int RW = 62,
  parameter int SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [RW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [RW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int HW = RW / 2;
  localparam int MW = HW + 2;

  logic [RW-1:0] rad_s  [HW+1];
  logic [MW-1:0] rem_s  [HW+1];
  logic [HW-1:0] root_s [HW+1];
  logic          v_s    [HW+1];
  logic [SW-1:0] side_s [HW+1];

  assign rad_s[0]  = rad_i;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign v_s[0]    = valid_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < HW; k++) begin : g_stage
    logic [RW-1:0] rad_q;
    logic [MW-1:0] rem_q;
    logic [HW-1:0] root_q;
    logic          v_q;
    logic [SW-1:0] side_q;
    logic [MW-1:0] rem_sh;
    logic [MW-1:0] trial;
    logic          ge;

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_s[k][MW-3:0], rad_s[k][RW-1 -: 2]};
    assign trial  = {root_s[k], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q  <= rad_s[k] << 2;
        rem_q  <= ge ? (rem_sh - trial) : rem_sh;
        root_q <= {root_s[k][HW-2:0], ge};
        side_q <= side_s[k];
      end
    end

    assign rad_s[k+1]  = rad_q;
    assign rem_s[k+1]  = rem_q;
    assign root_s[k+1] = root_q;
    assign v_s[k+1]    = v_q;
    assign side_s[k+1] = side_q;
  end

  assign valid_o = v_s[HW];
  assign root_o  = root_s[HW];
  assign side_o  = side_s[HW];

endmodule

### design/ldq_div.sv
// pipelined restoring divider, lanes share one divisor, one quotient bit per stage
module ldq_div import ldq_pkg::*; #(
  parameter int LN = 3,
  parameter int DW = 31,
  parameter int QW = 16,
  parameter int SW = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [LN-1:0][DW+QW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [SW-1:0]              side_i,
  output logic                       valid_o,
  output logic [LN-1:0][QW-1:0]      quo_o,
  output logic [SW-1:0]              side_o
);

  logic [LN-1:0][DW-1:0] rem_s  [QW+1];
  logic [LN-1:0][QW-1:0] low_s  [QW+1];
  logic [DW-1:0]         den_s  [QW+1];
  logic                  v_s    [QW+1];
  logic [SW-1:0]         side_s [QW+1];

  for (genvar l = 0; l < LN; l++) begin : g_lane
    assign rem_s[0][l] = num_i[l][DW+QW-1:QW];
    assign low_s[0][l] = num_i[l][QW-1:0];
  end
  assign den_s[0]  = den_i;
  assign v_s[0]    = valid_i;
  assign side_s[0] = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [LN-1:0][DW-1:0] rem_q;
    logic [LN-1:0][QW-1:0] low_q;
    logic [DW-1:0]         den_q;
    logic                  v_q;
    logic [SW-1:0]         side_q;
    logic [LN-1:0][DW-1:0] rem_d;
    logic [LN-1:0][QW-1:0] low_d;

    // numerator bits leave at the top of low, quotient bits enter at the bottom
    always_comb begin
      logic [DW:0] rsh;
      logic [DW:0] diff;
      logic        ge;
      for (int l = 0; l < LN; l++) begin
        rsh      = {rem_s[k][l], low_s[k][l][QW-1]};
        diff     = rsh - {1'b0, den_s[k]};
        ge       = (rsh >= {1'b0, den_s[k]});
        rem_d[l] = ge ? diff[DW-1:0] : rsh[DW-1:0];
        low_d[l] = {low_s[k][l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (en_i) begin
        v_q <= v_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= rem_d;
        low_q  <= low_d;
        den_q  <= den_s[k];
        side_q <= side_s[k];
      end
    end

    assign rem_s[k+1]  = rem_q;
    assign low_s[k+1]  = low_q;
    assign den_s[k+1]  = den_q;
    assign v_s[k+1]    = v_q;
    assign side_s[k+1] = side_q;
  end

  assign valid_o = v_s[QW];
  assign quo_o   = low_s[QW];
  assign side_o  = side_s[QW];

endmodule

### design/look_direction_to_quaternion.sv
// look-direction to quaternion: top level pipeline
//
// Input channel (in_valid_i / in_stall_o / in_item_i) takes a start and a target
// point, 16-bit signed with 8 fraction bits. Output channel (out_valid_o /
// out_stall_i / out_item_o) gives the quaternion in Q3.12 and a status code:
// ok, zero-length direction, or trace not positive (quaternion fields zero).
// Throughput is one item per cycle while in_stall_o is low. Each item passes
// through the two bit-serial square roots (31 and 30 stages) and the two
// 16-stage dividers plus the arithmetic stages around them.
// The pipeline advances as a whole. When the receiver stalls, the output
// register holds its item and the next finished item goes into a skid
// register; only while the skid register is full does in_stall_o go high and
// the pipeline freeze, so nothing is lost or repeated.
// Reset clears all valid bits and the skid register; the first item can be
// accepted right after reset is released.
module look_direction_to_quaternion import ldq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ldq_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ldq_out_t out_item_o
);

  logic en;
  logic skid_v_q;
  ldq_out_t skid_q;
  logic out_v_q;
  ldq_out_t out_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  // stage 1: differences
  logic s1_v_q;
  logic signed [16:0] d1_q [3];
  // stage 2: squares
  logic s2_v_q;
  logic [31:0] sq2_q [3];
  logic signed [16:0] d2_q [3];
  logic zero2_q;
  // stage 3: sum of squares
  logic s3_v_q;
  logic [33:0] sum3_q;
  logic signed [16:0] d3_q [3];
  logic zero3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [33:0] p;
    if (en) begin
      d1_q[0] <= 17'(in_item_i.to_x) - 17'(in_item_i.from_x);
      d1_q[1] <= 17'(in_item_i.to_y) - 17'(in_item_i.from_y);
      d1_q[2] <= 17'(in_item_i.to_z) - 17'(in_item_i.from_z);
      for (int c = 0; c < 3; c++) begin
        p        = d1_q[c] * d1_q[c];
        sq2_q[c] <= p[31:0];
        d2_q[c]  <= d1_q[c];
        d3_q[c]  <= d2_q[c];
      end
      zero2_q <= (d1_q[0] == '0) && (d1_q[1] == '0) && (d1_q[2] == '0);
      zero3_q <= zero2_q;
      sum3_q  <= 34'(sq2_q[0]) + 34'(sq2_q[1]) + 34'(sq2_q[2]);
    end
  end

  // length: r = floor(sqrt(sum * 2^28))
  logic        r_v;
  logic [30:0] r_root;
  logic [51:0] r_side;

  ldq_sqrt #(.RW(62), .SW(52)) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .rad_i   ({sum3_q, 28'd0}),
    .side_i  ({d3_q[0], d3_q[1], d3_q[2], zero3_q}),
    .valid_o (r_v),
    .root_o  (r_root),
    .side_o  (r_side)
  );

  // stage 4: rounded numerators for front = d * 2^28 / r
  logic s4_v_q;
  logic [2:0][46:0] num4_q;
  logic [30:0] r4_q;
  logic [2:0] sgn4_q;
  logic zero4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= r_v;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [16:0] dc;
    logic [16:0] dm;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dc         = r_side[51-17*c -: 17];
        dm         = dc[16] ? (17'd0 - dc) : dc;
        num4_q[c]  <= {3'd0, dm[15:0], 28'd0} + {17'd0, r_root[30:1]};
        sgn4_q[c]  <= dc[16];
      end
      r4_q    <= r_root;
      zero4_q <= r_side[0];
    end
  end

  logic            f_v;
  logic [2:0][15:0] f_quo;
  logic [3:0]      f_side;

  ldq_div #(.LN(3), .DW(31), .QW(16), .SW(4)) u_front_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .num_i   (num4_q),
    .den_i   (r4_q),
    .side_i  ({sgn4_q, zero4_q}),
    .valid_o (f_v),
    .quo_o   (f_quo),
    .side_o  (f_side)
  );

  // stage 5: front, clamped to unit and signed
  logic s5_v_q;
  logic signed [15:0] f5_q [3];
  logic zero5_q;
  // stage 6: products
  logic s6_v_q;
  logic signed [31:0] p01_q, p12_q, p00_q, p22_q;
  logic signed [15:0] f6_q [3];
  logic zero6_q;
  // stage 7: trace and quaternion numerators
  logic s7_v_q;
  logic [30:0] t7_q;
  logic signed [30:0] n7_q [3];
  logic [1:0] st7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= f_v;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [15:0] qc;
    logic signed [32:0] t;
    logic signed [32:0] nx;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        qc       = (f_quo[c] > FRONT_ONE) ? FRONT_ONE : f_quo[c];
        f5_q[c]  <= f_side[1+c] ? (16'd0 - qc) : qc;
        f6_q[c]  <= f5_q[c];
      end
      zero5_q <= f_side[0];

      p01_q   <= f5_q[0] * f5_q[1];
      p12_q   <= f5_q[1] * f5_q[2];
      p00_q   <= f5_q[0] * f5_q[0];
      p22_q   <= f5_q[2] * f5_q[2];
      zero6_q <= zero5_q;

      // trace = 1 + right.x + up.y + front.z, Q.28
      t  = 33'sd268435456 + (33'(f6_q[2]) <<< 15) + 33'(p00_q) + 33'(p22_q);
      nx = 33'sd0 - (33'(p12_q) + (33'(f6_q[1]) <<< 14));
      n7_q[0] <= nx[30:0];
      n7_q[1] <= 31'(f6_q[0]) <<< 15;
      n7_q[2] <= p01_q[30:0];
      t7_q    <= t[30:0];
      if (zero6_q) begin
        st7_q <= STATUS_ZERO_DIR;
      end else if (t <= 33'sd0) begin
        st7_q <= STATUS_BAD_TRACE;
      end else begin
        st7_q <= STATUS_OK;
      end
    end
  end

  // s = floor(sqrt(t * 2^28)) = 2w in Q.28
  logic        s_v;
  logic [29:0] s_root;
  logic [94:0] s_side;

  ldq_sqrt #(.RW(60), .SW(95)) u_trace_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s7_v_q),
    .rad_i   ({1'b0, t7_q, 28'd0}),
    .side_i  ({n7_q[0], n7_q[1], n7_q[2], st7_q}),
    .valid_o (s_v),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  // stage 8: w and rounded numerators for n * 2^11 / s
  logic s8_v_q;
  logic [2:0][45:0] num8_q;
  logic [29:0] s8_q;
  logic [13:0] w8_q;
  logic [2:0] sgn8_q;
  logic [1:0] st8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else if (en) begin
      s8_v_q <= s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [30:0] nc;
    logic [30:0] nm;
    logic [30:0] wr;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        nc        = s_side[94-31*c -: 31];
        nm        = nc[30] ? (31'd0 - nc) : nc;
        num8_q[c] <= {5'd0, nm[29:0], 11'd0} + {17'd0, s_root[29:1]};
        sgn8_q[c] <= nc[30];
      end
      wr    = {1'b0, s_root} + 31'd65536;
      w8_q  <= wr[30:17];
      s8_q  <= s_root;
      st8_q <= s_side[1:0];
    end
  end

  // quotient of 2^16 or more saturates that component's output
  logic [2:0] ovf8;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ovf8[c] = (num8_q[c] >= {s8_q, 16'd0});
    end
  end

  logic             q_v;
  logic [2:0][15:0] q_quo;
  logic [21:0]      q_side;

  ldq_div #(.LN(3), .DW(30), .QW(16), .SW(22)) u_quat_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_v_q),
    .num_i   (num8_q),
    .den_i   (s8_q),
    .side_i  ({w8_q, st8_q, ovf8, sgn8_q}),
    .valid_o (q_v),
    .quo_o   (q_quo),
    .side_o  (q_side)
  );

  // final saturation
  ldq_out_t res;
  always_comb begin
    logic [15:0] comp [3];
    logic [16:0] neg;
    logic        ovf;
    logic        sgn;
    for (int c = 0; c < 3; c++) begin
      ovf = q_side[3+c];
      sgn = q_side[c];
      neg = 17'd0 - {1'b0, q_quo[c]};
      if (!sgn) begin
        comp[c] = (ovf || q_quo[c][15]) ? 16'h7fff : q_quo[c];
      end else begin
        comp[c] = (ovf || (q_quo[c] > 16'h8000)) ? 16'h8000 : neg[15:0];
      end
    end
    res.status = q_side[7:6];
    if (q_side[7:6] == STATUS_OK) begin
      res.quat_w = {2'b00, q_side[21:8]};
      res.quat_x = comp[0];
      res.quat_y = comp[1];
      res.quat_z = comp[2];
    end else begin
      res.quat_w = '0;
      res.quat_x = '0;
      res.quat_y = '0;
      res.quat_z = '0;
    end
  end

  // output register with skid stage
  logic out_ready;
  assign out_ready = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_ready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= q_v;
      end
    end else if (q_v && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      out_q <= skid_v_q ? skid_q : res;
    end else if (q_v && en) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

### design/ldq_checker.sv
// port-level assertions for the look-direction quaternion unit, with bind
module ldq_checker import ldq_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input ldq_in_t  in_item_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input ldq_out_t out_item_o
);

  // input side only backs up once an output item has been held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("in_stall_o rose without a stalled output item");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == STATUS_OK ||
                     out_item_o.status == STATUS_ZERO_DIR ||
                     out_item_o.status == STATUS_BAD_TRACE))
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status != STATUS_OK) |->
      (out_item_o.quat_w == '0 && out_item_o.quat_x == '0 &&
       out_item_o.quat_y == '0 && out_item_o.quat_z == '0))
    else $error("failed item carries nonzero quaternion");

  a_w_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_item_o.quat_w[15])
    else $error("negative quaternion scalar part");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled output item changed");

endmodule

bind look_direction_to_quaternion ldq_checker u_ldq_checker (.*);

### test/ldq_checker.sv
// checker: predicts the quaternion of every accepted item and compares results
`timescale 1ns / 100ps
module ldq_scoreboard import ldq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  ldq_in_t  in_item_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  ldq_out_t out_item_i,
  output int       fail_cnt_o,
  output int       pending_o
);

  ldq_out_t quat_q[$];
  int mismatch_cnt;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint round_div(longint n, longint den);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag + den / 2) / den;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic ldq_out_t look_quat(ldq_in_t it);
    ldq_out_t o;
    longint d[3], f[3], rt[3], up[3];
    longint sq, r, s, t, nx, ny, nz, one;
    one = longint'(FRONT_ONE);
    o = '0;
    d[0] = longint'(it.to_x) - longint'(it.from_x);
    d[1] = longint'(it.to_y) - longint'(it.from_y);
    d[2] = longint'(it.to_z) - longint'(it.from_z);
    sq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    if (sq == 0) begin
      o.status = STATUS_ZERO_DIR;
      return o;
    end
    r = longint'(int_sqrt(64'(sq) << 28));
    for (int i = 0; i < 3; i++) begin
      f[i] = round_div(d[i] * (longint'(1) << 28), r);
      if (f[i] > one) f[i] = one;
      if (f[i] < -one) f[i] = -one;
    end
    rt[0] = f[2];
    rt[1] = 0;
    rt[2] = -f[0];
    up[0] = f[1] * rt[2] - f[2] * rt[1];
    up[1] = f[2] * rt[0] - f[0] * rt[2];
    up[2] = f[0] * rt[1] - f[1] * rt[0];
    t = (longint'(1) << 28) + rt[0] * one + up[1] + f[2] * one;
    if (t <= 0) begin
      o.status = STATUS_BAD_TRACE;
      return o;
    end
    s = longint'(int_sqrt(64'(t) << 28));
    nx = up[2] - f[1] * one;
    ny = f[0] * one - rt[2] * one;
    nz = rt[1] * one - up[0];
    o.quat_w = clip16(round_div(s, longint'(1) << 17));
    o.quat_x = clip16(round_div(nx * 2048, s));
    o.quat_y = clip16(round_div(ny * 2048, s));
    o.quat_z = clip16(round_div(nz * 2048, s));
    o.status = STATUS_OK;
    return o;
  endfunction

  assign fail_cnt_o = mismatch_cnt;
  assign pending_o = quat_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    ldq_out_t want;
    if (!rst_ni) begin
      mismatch_cnt <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) quat_q.push_back(look_quat(in_item_i));
      if (out_valid_i && !out_stall_i) begin
        if (quat_q.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) $display("unexpected item %p", out_item_i);
        end else begin
          want = quat_q.pop_front();
          if (want !== out_item_i) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10) $display("mismatch: expected %p, got %p", want, out_item_i);
          end
        end
      end
    end
  end

endmodule

### test/look_direction_to_quaternion_tb.sv
// testbench top: stimulus, receiver stalls and the verdict
`timescale 1ns / 100ps
module look_direction_to_quaternion_tb;
  import ldq_pkg::*;

  logic     clk_i, rst_ni;
  logic     in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  ldq_in_t  in_item_i;
  ldq_out_t out_item_o;
  int       fail_cnt, pending;
  bit       hold_off;

  look_direction_to_quaternion u_top (.*);

  ldq_scoreboard u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_item_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_item_i(out_item_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("look_direction_to_quaternion_tb: FAIL");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  function automatic logic signed [15:0] rnd_coord();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(ldq_in_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_gap(ldq_in_t it);
    int g;
    send(it);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // receiver: random stalls, plus one long hold-off
  initial begin
    int g;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
        out_stall_i <= 1'b0;
      end else begin
        g = gap_len();
        out_stall_i <= (g > 0);
        if (g > 1) repeat (g - 1) @(posedge clk_i);
      end
    end
  end

  initial begin
    ldq_in_t it;
    int wait_cyc;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    hold_off = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: zero direction, axes, -Z (bad trace), extremes, near -Z
    send('0);
    send('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
    send('{0, 0, 0, 0, 0, 256});
    send('{0, 0, 0, 0, 0, -256});
    send('{0, 0, 0, 256, 0, 0});
    send('{0, 0, 0, -256, 0, 0});
    send('{0, 0, 0, 0, 256, 0});
    send('{0, 0, 0, 0, -256, 0});
    send('{0, 0, 0, 1, 0, -32768});
    send('{0, 0, 0, 0, 1, -32768});
    send('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000});
    send('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    send('{0, 0, 16'sh7fff, 0, 0, 16'sh8000});
    send('{0, 0, 16'sh8000, 0, 0, 16'sh7fff});
    send('{0, 0, 0, 0, 0, 1});
    send('{0, 0, 0, 0, 0, -1});
    send('{0, 0, 0, 1, 1, 1});
    send('{-5, 7, 3, -5, 7, 3});
    for (int n = 0; n < 1250; n++) begin
      if (n == 300) hold_off = 1;
      it = '{rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
             rnd_coord()};
      if ($urandom_range(0, 29) == 0) it.to_x = it.from_x;
      if ($urandom_range(0, 29) == 0) begin
        it.to_x = it.from_x;
        it.to_y = it.from_y;
        it.to_z = it.from_z;
      end
      if (n < 300) send(it);
      else send_gap(it);
    end
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    wait_cyc = 0;
    while (wait_cyc < 300) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    if (fail_cnt == 0 && pending == 0)
      $display("look_direction_to_quaternion_tb: PASS");
    else
      $display("look_direction_to_quaternion_tb: FAIL");
    $finish;
  end

endmodule
